// ===== src/scdp_pkg.sv =====
package scdp_pkg;

    localparam int MAX_CHARS = 5;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int DUTY_W    = 16;
    localparam int BYTE_W    = 8;

    localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

    localparam logic [BYTE_W-1:0] CH_Z    = 8'h7a;
    localparam logic [BYTE_W-1:0] CH_Y    = 8'h79;
    localparam logic [BYTE_W-1:0] CH_E    = 8'h65;
    localparam logic [BYTE_W-1:0] CH_D    = 8'h64;
    localparam logic [BYTE_W-1:0] CH_I    = 8'h69;
    localparam logic [BYTE_W-1:0] CH_S    = 8'h73;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_Z    = 3'b010,
        MODE_Y    = 3'b100
    } t_mode;

    typedef struct packed {
        logic              echo_valid;
        logic [BYTE_W-1:0] echo_byte;
        logic [DUTY_W-1:0] z_duty;
        logic [DUTY_W-1:0] y_duty;
        logic              enable_pin;
        logic              aux_pin;
        logic              busy_res;
    } t_result;

endpackage

// ===== src/serial_command_duty_parser.sv =====
// serial command parser driving two duty values and two pin levels
//
// input channel: i_in_valid / i_rx_byte, with o_in_stall back to the sender;
// an item is taken on a rising edge with valid high and stall low
// output channel: o_out_valid plus the result fields, with i_out_stall from
// the receiver; every input item gives exactly one result item
// an item taken passes the input register, then the result register, which
// loads only while the output is not stalled
// throughput: one item per cycle unless the output stalls; a single input
// register and a single result register, decode and number update between
// reset (i_rst_n low, synchronous): idle, duties zero, pins low, busy low
// in the parser state, both channels empty; the result fields are not reset
// a stalled result holds; one more item is still taken into the input
// register, after which o_in_stall rises until the result is taken
// echo_byte is zero whenever echo_valid is low
module serial_command_duty_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [scdp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_echo_valid,
    output logic [scdp_pkg::BYTE_W-1:0] o_echo_byte,
    output logic [scdp_pkg::DUTY_W-1:0] o_z_duty,
    output logic [scdp_pkg::DUTY_W-1:0] o_y_duty,
    output logic                        o_enable_pin,
    output logic                        o_aux_pin,
    output logic                        o_busy_res
);
    import scdp_pkg::*;

    logic              advance;
    logic              fire;
    logic              st_vld;
    logic [BYTE_W-1:0] st_byte;
    t_result           next_res;
    t_result           r_res;
    logic              r_out_vld;

    assign advance = !r_out_vld || !i_out_stall;
    assign fire    = st_vld && advance;

    scdp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .o_in_stall (o_in_stall),
        .i_advance  (advance),
        .o_vld      (st_vld),
        .o_byte     (st_byte)
    );

    scdp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (st_byte),
        .o_result (next_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= st_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= next_res;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_echo_valid = r_res.echo_valid;
    assign o_echo_byte  = r_res.echo_byte;
    assign o_z_duty     = r_res.z_duty;
    assign o_y_duty     = r_res.y_duty;
    assign o_enable_pin = r_res.enable_pin;
    assign o_aux_pin    = r_res.aux_pin;
    assign o_busy_res   = r_res.busy_res;

endmodule

// ===== src/scdp_in_stage.sv =====
module scdp_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [scdp_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                        o_in_stall,
    input  logic                        i_advance,
    output logic                        o_vld,
    output logic [scdp_pkg::BYTE_W-1:0] o_byte
);
    import scdp_pkg::*;

    logic              r_vld;
    logic [BYTE_W-1:0] r_byte;
    logic              n_vld;
    logic              load;

    assign o_in_stall = r_vld && !i_advance;
    assign load       = i_in_valid && !o_in_stall;

    always_comb begin
        n_vld = r_vld;
        if (load) begin
            n_vld = 1'b1;
        end else if (i_advance) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_vld  = r_vld;
    assign o_byte = r_byte;

endmodule

// ===== src/scdp_core.sv =====
module scdp_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [scdp_pkg::BYTE_W-1:0] i_byte,
    output scdp_pkg::t_result           o_result
);
    import scdp_pkg::*;

    t_mode             r_mode,   n_mode;
    logic [CNT_W-1:0]  r_count,  n_count;
    logic [DUTY_W-1:0] r_acc,    n_acc;
    logic              r_seen,   n_seen;
    logic              r_stop,   n_stop;
    logic [DUTY_W-1:0] r_z,      n_z;
    logic [DUTY_W-1:0] r_y,      n_y;
    logic              r_en,     n_en;
    logic              r_aux,    n_aux;
    logic              r_busy,   n_busy;
    logic              echo;
    logic              collecting;
    logic              is_digit;
    logic [3:0]        digit;
    logic [DUTY_W+3:0] acc_x10;

    assign collecting = (r_mode == MODE_Z) || (r_mode == MODE_Y);
    assign is_digit   = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit      = 4'(i_byte - CH_0);
    // times ten plus the digit, as two shifts and two adds
    assign acc_x10    = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {16'b0, digit};

    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        n_acc   = r_acc;
        n_seen  = r_seen;
        n_stop  = r_stop;
        n_z     = r_z;
        n_y     = r_y;
        n_en    = r_en;
        n_aux   = r_aux;
        n_busy  = r_busy;
        echo    = 1'b0;
        if (collecting) begin
            if (i_byte == CH_CR) begin
                if (r_seen) begin
                    if (r_mode == MODE_Z) begin
                        n_z = r_acc;
                    end else begin
                        n_y = r_acc;
                    end
                end
                n_busy  = 1'b0;
                n_mode  = MODE_IDLE;
                n_count = '0;
                n_acc   = '0;
                n_seen  = 1'b0;
                n_stop  = 1'b0;
            end else begin
                echo = 1'b1;
                // bytes past the buffer length are echoed only
                if (r_count < CNT_W'(MAX_CHARS)) begin
                    n_count = r_count + 1'b1;
                    if (!r_stop) begin
                        if (is_digit) begin
                            n_acc  = (acc_x10 > {4'b0, DUTY_MAX}) ? DUTY_MAX
                                                                  : acc_x10[DUTY_W-1:0];
                            n_seen = 1'b1;
                        end else begin
                            n_stop = 1'b1;
                        end
                    end
                end
            end
        end else begin
            n_mode  = MODE_IDLE;
            n_count = '0;
            n_acc   = '0;
            n_seen  = 1'b0;
            n_stop  = 1'b0;
            echo    = 1'b1;
            case (i_byte)
                CH_Z:    n_mode = MODE_Z;
                CH_Y:    n_mode = MODE_Y;
                CH_E:    n_en   = 1'b0;
                CH_D:    n_en   = 1'b1;
                CH_I:    n_aux  = 1'b1;
                CH_S:    n_aux  = 1'b0;
                default: echo   = 1'b0;
            endcase
            if (echo) begin
                n_busy = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_count <= '0;
            r_acc   <= '0;
            r_seen  <= 1'b0;
            r_stop  <= 1'b0;
            r_z     <= '0;
            r_y     <= '0;
            r_en    <= 1'b0;
            r_aux   <= 1'b0;
            r_busy  <= 1'b0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_stop  <= n_stop;
            r_z     <= n_z;
            r_y     <= n_y;
            r_en    <= n_en;
            r_aux   <= n_aux;
            r_busy  <= n_busy;
        end
    end

    always_comb begin
        o_result.echo_valid = echo;
        o_result.echo_byte  = echo ? i_byte : '0;
        o_result.z_duty     = n_z;
        o_result.y_duty     = n_y;
        o_result.enable_pin = n_en;
        o_result.aux_pin    = n_aux;
        o_result.busy_res   = n_busy;
    end

    a_collect_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_IDLE) |-> r_busy)
        else $error("collecting without busy");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CHARS))
        else $error("kept byte count overrun");

    a_acc_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_acc != '0) || r_stop) |-> (r_count != '0))
        else $error("number state without kept bytes");

    a_start_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (r_mode == MODE_IDLE) && (i_byte == CH_Z))
            |=> (r_mode == MODE_Z) && r_busy && (r_count == '0))
        else $error("z command did not start a number");

endmodule
